>>> rtl/tdfsm_pkg.sv
// Shared types and codes for the table-driven FSM runner.
// Holds the input/output word structs, item modes, end kinds and controller states.
package tdfsm_pkg;

  typedef enum logic [2:0] {
    MODE_STATE_WR  = 3'd0,
    MODE_BRANCH_WR = 3'd1,
    MODE_SLOT_WR   = 3'd2,
    MODE_START     = 3'd3,
    MODE_SYMBOL    = 3'd4,
    MODE_END       = 3'd5
  } mode_t;

  localparam logic [1:0] END_COMPLETE = 2'd0;
  localparam logic [1:0] END_NO_STEPS = 2'd1;
  localparam logic [1:0] END_HOP_CAP  = 2'd2;

  localparam logic [15:0] UNLIMITED_BUDGET = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  state_sel;
    logic [1:0]  branch_sel;
    logic [2:0]  slot_sel;
    logic [7:0]  symbol;
    logic        entry_valid;
    logic [3:0]  dest_state;
    logic        reverse_test;
    logic        terminate_now;
    logic        loop_default;
    logic [1:0]  completion_code;
    logic [15:0] step_budget;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  final_state;
    logic [15:0] symbols_consumed;
    logic [1:0]  end_kind;
    logic [1:0]  state_code;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_SETTLE,
    ST_TERM,
    ST_EMIT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       tbl_wr;
    logic       start;
    logic       begin_sym;
    logic       clr_branch;
    logic       next_branch;
    logic       fire;
    logic       loop_take;
    logic       set_kind;
    logic [1:0] kind;
    logic       emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_ok;
    logic active;
    logic steps_zero;
    logic fire;
    logic hit;
    logic last_branch;
    logic loop_en;
    logic term;
    logic hop_cap;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/tdfsm_ctrl.sv
// Controller for the table-driven FSM runner: sequences table writes, runs and hops.
// Depends on tdfsm_pkg; drives the datapath through dp_cmd_t, watches dp_status_t.
module tdfsm_ctrl
  import tdfsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_mode,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        hop_r, hop_nxt;
  logic        accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Hold state and hop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hop_r   <= hop_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    hop_nxt   = hop_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode) inside
            MODE_START: begin
              if (status.start_ok) begin
                state_nxt = ST_SETTLE;
                hop_nxt   = 1'b0;
              end
            end
            MODE_END:    if (status.active) state_nxt = ST_EMIT;
            MODE_SYMBOL: if (status.active) state_nxt = ST_CHECK;
            default: ;
          endcase
        end
      end
      ST_CHECK: state_nxt = status.steps_zero ? ST_EMIT : ST_READ;
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (status.fire) begin
          state_nxt = ST_SETTLE;
          hop_nxt   = !status.hit;
        end else if (status.last_branch) begin
          state_nxt = status.loop_en ? ST_IDLE : ST_EMIT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_SETTLE: state_nxt = ST_TERM;
      ST_TERM: begin
        if (status.term)                    state_nxt = ST_EMIT;
        else if (hop_r && status.hop_cap)   state_nxt = ST_EMIT;
        else if (hop_r)                     state_nxt = ST_CHECK;
        else                                state_nxt = ST_IDLE;
      end
      ST_EMIT: if (status.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode) inside
            MODE_STATE_WR, MODE_BRANCH_WR, MODE_SLOT_WR: cmd.tbl_wr = 1'b1;
            MODE_START: cmd.start = status.start_ok;
            MODE_END: begin
              cmd.set_kind = status.active;
              cmd.kind     = END_COMPLETE;
            end
            MODE_SYMBOL: cmd.begin_sym = status.active;
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        cmd.set_kind   = status.steps_zero;
        cmd.kind       = END_NO_STEPS;
        cmd.clr_branch = !status.steps_zero;
      end
      ST_READ: ;
      ST_EVAL: begin
        if (status.fire) begin
          cmd.fire = 1'b1;
        end else if (status.last_branch) begin
          cmd.loop_take = status.loop_en;
          cmd.set_kind  = !status.loop_en;
          cmd.kind      = END_COMPLETE;
        end else begin
          cmd.next_branch = 1'b1;
        end
      end
      ST_SETTLE: ;
      ST_TERM: begin
        if (status.term) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = END_COMPLETE;
        end else if (hop_r && status.hop_cap) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = END_HOP_CAP;
        end
      end
      ST_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/tdfsm_dp.sv
// Datapath for the table-driven FSM runner: tables, run registers, match logic, output word.
// Depends on tdfsm_pkg; commanded by tdfsm_ctrl.
module tdfsm_dp
  import tdfsm_pkg::*;
#(
  parameter int NUM_STATES         = 16,
  parameter int BRANCHES_PER_STATE = 4,
  parameter int SET_SLOTS          = 8,
  parameter int MAX_HOPS           = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_word_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  localparam int SW   = $clog2(NUM_STATES);
  localparam int NB   = NUM_STATES * BRANCHES_PER_STATE;
  localparam int RW   = $clog2(NB);
  localparam int BW   = (BRANCHES_PER_STATE > 1) ? $clog2(BRANCHES_PER_STATE) : 1;
  localparam int TW   = (SET_SLOTS > 1) ? $clog2(SET_SLOTS) : 1;
  localparam int HW   = $clog2(MAX_HOPS + 1);

  typedef struct packed {
    logic          valid;
    logic          rev;
    logic [SW-1:0] dest;
  } branch_t;

  typedef struct packed {
    logic       used;
    logic [7:0] sym;
  } slot_t;

  // Reduce a 4-bit destination into the state range
  function automatic logic [SW-1:0] wrap_dest(input logic [3:0] d);
    logic [8:0] v;
    v = 9'(d);
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= NUM_STATES) v = 9'(32'(v) - NUM_STATES);
    end
    return SW'(v);
  endfunction

  // Tables
  logic [3:0]    attr_mem [NUM_STATES];
  branch_t       br_mem   [NB];
  slot_t [SET_SLOTS-1:0] set_mem [NB];
  logic [NB-1:0] br_ok_r;
  logic [NB-1:0] row_ok_r;

  // Run registers
  logic [SW-1:0] cur_r;
  logic [15:0]   consumed_r;
  logic [15:0]   steps_r;
  logic          active_r;
  logic [HW-1:0] hops_r;
  logic [BW-1:0] b_r;
  logic [7:0]    sym_r;
  logic [1:0]    kind_r;

  // Read registers
  logic [3:0]            attr_rd_r;
  branch_t               br_rd_r;
  slot_t [SET_SLOTS-1:0] row_rd_r;

  logic                  out_valid_r;
  out_word_t             out_r;

  // Write decode
  logic          st_ok, br_sel_ok, slot_ok;
  logic [RW-1:0] wr_row;
  logic [RW-1:0] rd_row;
  logic [TW-1:0] wr_slot;
  slot_t         wr_entry;
  logic [2:0]    mode;

  assign mode      = in_data.mode;
  assign st_ok     = 32'(in_data.state_sel) < NUM_STATES;
  assign br_sel_ok = st_ok && (32'(in_data.branch_sel) < BRANCHES_PER_STATE);
  assign slot_ok   = br_sel_ok && (32'(in_data.slot_sel) < SET_SLOTS);
  assign wr_row    = RW'(32'(in_data.state_sel) * BRANCHES_PER_STATE
                         + 32'(in_data.branch_sel));
  assign wr_slot   = TW'(in_data.slot_sel);
  assign wr_entry  = '{used: in_data.entry_valid, sym: in_data.symbol};
  assign rd_row    = RW'(32'(cur_r) * BRANCHES_PER_STATE + 32'(b_r));

  // Write and read state attributes
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && mode == MODE_STATE_WR && st_ok) begin
      attr_mem[SW'(in_data.state_sel)] <= {in_data.completion_code,
                                           in_data.loop_default, in_data.terminate_now};
    end
    attr_rd_r <= attr_mem[cur_r];
  end

  // Write and read branch entries
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && mode == MODE_BRANCH_WR && br_sel_ok) begin
      br_mem[wr_row] <= '{valid: in_data.entry_valid, rev: in_data.reverse_test,
                          dest: wrap_dest(in_data.dest_state)};
    end
    br_rd_r <= br_ok_r[rd_row] ? br_mem[rd_row] : '0;
  end

  // Write and read accepted-symbol rows; a fresh row fills its other slots with zero
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && mode == MODE_SLOT_WR && slot_ok) begin
      for (int k = 0; k < SET_SLOTS; k++) begin
        if (TW'(k) == wr_slot) set_mem[wr_row][k] <= wr_entry;
        else if (!row_ok_r[wr_row]) set_mem[wr_row][k] <= '0;
      end
    end
    row_rd_r <= row_ok_r[rd_row] ? set_mem[rd_row] : '0;
  end

  // Track written rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_ok_r  <= '0;
      row_ok_r <= '0;
    end else if (cmd.tbl_wr) begin
      if (mode == MODE_BRANCH_WR && br_sel_ok) br_ok_r[wr_row] <= 1'b1;
      if (mode == MODE_SLOT_WR && slot_ok)     row_ok_r[wr_row] <= 1'b1;
    end
  end

  // Match the held symbol against the branch set
  logic any_used, any_match, hit, fire;
  always_comb begin
    any_used  = 1'b0;
    any_match = 1'b0;
    for (int k = 0; k < SET_SLOTS; k++) begin
      if (row_rd_r[k].used) begin
        any_used = 1'b1;
        if (row_rd_r[k].sym == sym_r) any_match = 1'b1;
      end
    end
    hit  = any_match || !any_used;
    fire = br_rd_r.valid && (br_rd_r.rev ? !hit : hit);
  end

  logic [15:0] steps_spent;
  logic [15:0] consumed_inc;
  assign steps_spent  = (steps_r != UNLIMITED_BUDGET && steps_r != 16'd0)
                        ? steps_r - 16'd1 : steps_r;
  assign consumed_inc = (consumed_r != 16'hFFFF) ? consumed_r + 16'd1 : consumed_r;

  // Run control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      consumed_r <= '0;
      steps_r    <= '0;
      active_r   <= 1'b0;
      hops_r     <= '0;
      b_r        <= '0;
      kind_r     <= END_COMPLETE;
    end else begin
      if (cmd.start) begin
        cur_r      <= SW'(in_data.state_sel);
        consumed_r <= '0;
        steps_r    <= in_data.step_budget;
        active_r   <= 1'b1;
      end
      if (cmd.begin_sym)   hops_r <= '0;
      if (cmd.clr_branch)  b_r <= '0;
      if (cmd.next_branch) b_r <= b_r + BW'(1);
      if (cmd.fire) begin
        steps_r <= steps_spent;
        cur_r   <= br_rd_r.dest;
        if (hit) consumed_r <= consumed_inc;
        else     hops_r     <= hops_r + HW'(1);
      end
      if (cmd.loop_take) begin
        steps_r    <= steps_spent;
        consumed_r <= consumed_inc;
      end
      if (cmd.set_kind) kind_r <= cmd.kind;
      if (cmd.emit)     active_r <= 1'b0;
    end
  end

  // Hold the symbol of the item in flight
  always_ff @(posedge clk) begin
    if (cmd.begin_sym) sym_r <= in_data.symbol;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.final_state      <= 4'(cur_r);
      out_r.symbols_consumed <= consumed_r;
      out_r.end_kind         <= kind_r;
      out_r.state_code       <= attr_rd_r[3:2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign status.start_ok    = st_ok;
  assign status.active      = active_r;
  assign status.steps_zero  = (steps_r == 16'd0);
  assign status.fire        = fire;
  assign status.hit         = hit;
  assign status.last_branch = (32'(b_r) == BRANCHES_PER_STATE - 1);
  assign status.loop_en     = attr_rd_r[1];
  assign status.term        = attr_rd_r[0];
  assign status.hop_cap     = (32'(hops_r) >= MAX_HOPS);
  assign status.out_free    = !out_valid_r;

endmodule

>>> rtl/table_driven_fsm_runner.sv
// Table-driven FSM runner. Table writes and idle items are taken in the idle state; a start
// passes through settle and attribute-check states. A symbol is accepted, then for each state
// it visits gets a step check, a table read and a compare per branch tried, and a settle and
// an attribute read of the new state when a branch is taken; an ending run loads the result
// register, waiting while the previous result is still held. One item is in work at a time.
// Synchronous active-low reset clears control state and the written-row flags.
module table_driven_fsm_runner
  import tdfsm_pkg::*;
#(
  parameter int NUM_STATES         = 16,
  parameter int BRANCHES_PER_STATE = 4,
  parameter int SET_SLOTS          = 8,
  parameter int MAX_HOPS           = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tdfsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdfsm_dp #(
    .NUM_STATES         (NUM_STATES),
    .BRANCHES_PER_STATE (BRANCHES_PER_STATE),
    .SET_SLOTS          (SET_SLOTS),
    .MAX_HOPS           (MAX_HOPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
